### hw/rtl/trie_lpm_pkg.sv
package trie_lpm_pkg;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      RSP_INSERTED  = 2'd0,
      RSP_DUPLICATE = 2'd1,
      RSP_FULL      = 2'd2,
      RSP_ANSWER    = 2'd3
   } status_code_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  text_byte;
      logic        last;
      logic [15:0] entry_value;
   } req_type;

   typedef struct packed {
      status_code_type status;
      logic            exact_hit;
      logic            prefix_hit;
      logic [15:0]     match_value;
      logic [15:0]     match_length;
   } rsp_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_CHILD,
      FSM_VALUE
   } fsm_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic child_step;
      logic value_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dpath_status_type;

endpackage

### hw/rtl/trie_lpm_ram.sv
module trie_lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/trie_lpm_ctrl.sv
module trie_lpm_ctrl
   import trie_lpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dpath_status_type status,
   output ctrl_cmd_type     cmd,
   output logic             busy
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         FSM_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = FSM_CHILD;
            end
         end
         FSM_CHILD: begin
            cmd.child_step = 1'b1;
            state_in       = FSM_VALUE;
         end
         FSM_VALUE: begin
            cmd.value_step = 1'b1;
            state_in       = FSM_IDLE;
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

endmodule

### hw/rtl/trie_lpm_dpath.sv
module trie_lpm_dpath
   import trie_lpm_pkg::*;
#(
   parameter int NODE_COUNT  = 256,
   parameter int VALUE_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   output dpath_status_type status,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   localparam int NW       = $clog2(NODE_COUNT);
   localparam int AW       = NW + 8;
   localparam int UW       = $clog2(NODE_COUNT + 1);
   localparam int VW1      = VALUE_WIDTH + 1;
   localparam int CLR_LAST = NODE_COUNT * 256 - 1;

   logic [NW-1:0]          cursor_ff, cursor_in;
   logic [UW-1:0]          used_ff, used_in;
   logic                   dead_ff, dead_in;
   logic                   adv_ff, adv_in;
   logic [15:0]            bytes_ff, bytes_in;
   logic                   found_ff, found_in;
   logic [VALUE_WIDTH-1:0] best_value_ff, best_value_in;
   logic [15:0]            best_len_ff, best_len_in;
   logic [AW-1:0]          clr_ff, clr_in;
   req_type                req_ff, req_in;
   logic                   strobe_ff, strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   c_we, c_re;
   logic [AW-1:0]          c_waddr, c_raddr;
   logic [NW-1:0]          c_wdata, c_rdata;
   logic                   v_we, v_re;
   logic [NW-1:0]          v_waddr, v_raddr;
   logic [VW1-1:0]         v_wdata, v_rdata;

   trie_lpm_ram #(
      .WIDTH (NW),
      .DEPTH (NODE_COUNT * 256)
   ) u_child_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .re    (c_re),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   trie_lpm_ram #(
      .WIDTH (VW1),
      .DEPTH (NODE_COUNT)
   ) u_value_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .re    (v_re),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         used_ff     <= UW'(1);
         dead_ff     <= 1'b0;
         adv_ff      <= 1'b0;
         bytes_ff    <= '0;
         found_ff    <= 1'b0;
         best_len_ff <= '0;
         clr_ff      <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         used_ff     <= used_in;
         dead_ff     <= dead_in;
         adv_ff      <= adv_in;
         bytes_ff    <= bytes_in;
         found_ff    <= found_in;
         best_len_ff <= best_len_in;
         clr_ff      <= clr_in;
         strobe_ff   <= strobe_in;
      end
      best_value_ff <= best_value_in;
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      logic [NW-1:0]          child;
      logic                   alloc;
      logic                   hit;
      logic                   has;
      logic                   nfound;
      logic [VALUE_WIDTH-1:0] nvalue;
      logic [15:0]            nlen;
      logic [63:0]            wide_value;
      logic [63:0]            wide_entry;

      cursor_in     = cursor_ff;
      used_in       = used_ff;
      dead_in       = dead_ff;
      adv_in        = adv_ff;
      bytes_in      = bytes_ff;
      found_in      = found_ff;
      best_value_in = best_value_ff;
      best_len_in   = best_len_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      strobe_in     = 1'b0;
      rsp_in        = rsp_ff;

      c_we    = 1'b0;
      c_waddr = {cursor_ff, req_ff.text_byte};
      c_wdata = used_ff[NW-1:0];
      c_re    = 1'b0;
      c_raddr = {cursor_ff, req_data.text_byte};
      v_we    = 1'b0;
      v_waddr = cursor_ff;
      v_wdata = '0;
      v_re    = 1'b0;
      v_raddr = c_rdata;

      status.clear_last = (clr_ff == AW'(CLR_LAST));

      child      = c_rdata;
      alloc      = 1'b0;
      has        = v_rdata[VALUE_WIDTH];
      hit        = adv_ff & has;
      nfound     = found_ff | hit;
      nvalue     = hit ? v_rdata[VALUE_WIDTH-1:0] : best_value_ff;
      nlen       = hit ? bytes_ff : best_len_ff;
      wide_value = 64'(nvalue);
      wide_entry = 64'(req_ff.entry_value);

      if (cmd.clear_step) begin
         c_we    = 1'b1;
         c_waddr = clr_ff;
         c_wdata = '0;
         if (clr_ff[7:0] == 8'd0) begin
            v_we    = 1'b1;
            v_waddr = clr_ff[AW-1:8];
            v_wdata = '0;
         end
         clr_in = clr_ff + AW'(1);
      end

      if (cmd.accept) begin
         c_re   = 1'b1;
         req_in = req_data;
         adv_in = 1'b0;
      end

      if (cmd.child_step && !dead_ff) begin
         alloc = (c_rdata == '0) && (req_ff.kind == KIND_INSERT) &&
                 (used_ff < UW'(NODE_COUNT));
         if (alloc) begin
            c_we    = 1'b1;
            child   = used_ff[NW-1:0];
            used_in = used_ff + UW'(1);
         end
         if (child == '0) begin
            dead_in = 1'b1;
         end else begin
            cursor_in = child;
            adv_in    = 1'b1;
            v_re      = 1'b1;
            v_raddr   = child;
            if (bytes_ff != 16'hFFFF) begin
               bytes_in = bytes_ff + 16'd1;
            end
         end
      end

      if (cmd.value_step) begin
         if (req_ff.last) begin
            strobe_in = 1'b1;
            rsp_in    = '0;
            if (req_ff.kind == KIND_QUERY) begin
               rsp_in.status     = RSP_ANSWER;
               rsp_in.exact_hit  = ~dead_ff & has;
               rsp_in.prefix_hit = nfound;
               if (nfound) begin
                  rsp_in.match_value  = wide_value[15:0];
                  rsp_in.match_length = nlen;
               end
            end else if (dead_ff) begin
               rsp_in.status = RSP_FULL;
            end else if (has) begin
               rsp_in.status = RSP_DUPLICATE;
            end else begin
               rsp_in.status = RSP_INSERTED;
               v_we          = 1'b1;
               v_waddr       = cursor_ff;
               v_wdata       = {1'b1, wide_entry[VALUE_WIDTH-1:0]};
            end
            cursor_in     = '0;
            dead_in       = 1'b0;
            bytes_in      = '0;
            found_in      = 1'b0;
            best_value_in = '0;
            best_len_in   = '0;
         end else begin
            found_in      = nfound;
            best_value_in = nvalue;
            best_len_in   = nlen;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hw/rtl/trie_lpm_top.sv
// Channel   Ports                       Handshake
// request   req_data (req_type)         start high while busy low
// response  rsp_data (rsp_type)         rsp_strobe high, one cycle
//
// Each byte beat goes through accept, child-table read (plus node
// allocation on insert), value-table read (plus attach on the last byte).
// After reset a clearing pass sweeps the child table and the value table
// with busy high. The response of a last byte appears in the cycle after
// its value-table read, in parallel with the next accept.
// The receiver cannot stall; responses are never held.
module trie_longest_prefix_matcher_unit
   import trie_lpm_pkg::*;
#(
   parameter int NODE_COUNT  = 256,
   parameter int VALUE_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   trie_lpm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   trie_lpm_dpath #(
      .NODE_COUNT  (NODE_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### test/testbench.sv
module testbench;
   import trie_lpm_pkg::*;

   localparam int NODES = 256;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   trie_longest_prefix_matcher_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // trie mirror
   logic [7:0]  child_of [0:NODES*256-1];
   bit          node_valid [0:NODES-1];
   logic [15:0] node_val [0:NODES-1];
   int          nodes_used;
   int          cursor;
   bit          walk_dead;
   logic [15:0] best_value;
   int          best_length;
   int          depth_seen;
   bit          best_found;

   rsp_type     due_rsps[$];
   rsp_type     got;
   rsp_type     want;
   int          errors;
   int          beats_sent;
   int          rsps_checked;
   int          status_seen [0:3];
   bit          burst_mode;
   logic [7:0]  alphabet [0:2];
   logic [7:0]  last_key[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void restart_walk();
      cursor      = 0;
      walk_dead   = 1'b0;
      best_value  = '0;
      best_length = 0;
      depth_seen  = 0;
      best_found  = 1'b0;
   endfunction

   function automatic void trie_walk_beat(input req_type beat, output bit has_rsp,
                                          output rsp_type rsp);
      int slot;
      int child;
      has_rsp = 1'b0;
      rsp     = '0;
      if (!walk_dead) begin
         slot  = cursor * 256 + int'(beat.text_byte);
         child = int'(child_of[slot]);
         if (child == 0 && beat.kind == KIND_INSERT && nodes_used < NODES) begin
            child          = nodes_used;
            child_of[slot] = child[7:0];
            nodes_used++;
         end
         if (child == 0) begin
            walk_dead = 1'b1;
         end else begin
            cursor = child;
            if (depth_seen < 65535) depth_seen++;
            if (node_valid[child]) begin
               best_found  = 1'b1;
               best_value  = node_val[child];
               best_length = depth_seen;
            end
         end
      end
      if (beat.last) begin
         has_rsp = 1'b1;
         if (beat.kind == KIND_QUERY) begin
            rsp.status     = RSP_ANSWER;
            rsp.exact_hit  = !walk_dead && node_valid[cursor];
            rsp.prefix_hit = best_found;
            rsp.match_value  = best_found ? best_value : 16'd0;
            rsp.match_length = best_found ? best_length[15:0] : 16'd0;
         end else if (walk_dead) begin
            rsp.status = RSP_FULL;
         end else if (node_valid[cursor]) begin
            rsp.status = RSP_DUPLICATE;
         end else begin
            node_valid[cursor] = 1'b1;
            node_val[cursor]   = beat.entry_value;
            rsp.status         = RSP_INSERTED;
         end
         restart_walk();
      end
   endfunction

   // start stays high across back-to-back beats; lowered only ahead of a gap
   task automatic send_beat(input kind_type kind, input logic [7:0] text_byte,
                            input bit last, input logic [15:0] val);
      req_type beat;
      bit      has_rsp;
      rsp_type rsp;
      int      gap;
      beat.kind        = kind;
      beat.text_byte   = text_byte;
      beat.last        = last;
      beat.entry_value = val;
      gap = burst_mode ? 0 : int'($urandom_range(0, 7));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= beat;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      beats_sent++;
      trie_walk_beat(beat, has_rsp, rsp);
      if (has_rsp) due_rsps = {due_rsps, rsp};
   endtask

   task automatic send_text(input kind_type kind, input logic [7:0] text[$],
                            input logic [15:0] val);
      for (int i = 0; i < text.size(); i++)
         send_beat(kind, text[i], i == text.size() - 1, val);
   endtask

   // mixed: every byte but the last gets a random kind
   task automatic send_string(input kind_type kind, input int len, input bit wide,
                              input bit mixed);
      logic [7:0] text[$];
      logic [7:0] b;
      kind_type   k;
      for (int i = 0; i < len; i++) begin
         if (wide || $urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
         else b = alphabet[$urandom_range(0, 2)];
         text = {text, b};
      end
      last_key = text;
      if (!mixed) begin
         send_text(kind, text, 16'($urandom_range(0, 65535)));
      end else begin
         for (int i = 0; i < len; i++) begin
            k = (i == len - 1) ? kind : kind_type'($urandom_range(0, 1));
            send_beat(k, text[i], i == len - 1, 16'($urandom_range(0, 65535)));
         end
      end
   endtask

   task automatic test_directed();
      send_beat(KIND_INSERT, 8'h00, 1'b1, 16'hffff);
      send_beat(KIND_INSERT, 8'h00, 1'b1, 16'h1234);   // duplicate
      send_text(KIND_INSERT, '{8'h00, 8'hff}, 16'h0000);
      send_beat(KIND_QUERY, 8'h00, 1'b1, 16'hffff);     // exact
      send_text(KIND_QUERY, '{8'h00, 8'hff, 8'h7e}, 16'h0000);
      send_beat(KIND_QUERY, 8'hff, 1'b1, 16'h5555);     // miss at root
      send_text(KIND_QUERY, '{8'hff, 8'h00}, 16'haaaa); // dead walk ignores rest
      send_text(KIND_QUERY, '{8'h00, 8'h81}, 16'h0000);
      send_beat(KIND_INSERT, 8'h33, 1'b0, 16'h0001);    // mixed, ends on query
      send_beat(KIND_QUERY, 8'h44, 1'b1, 16'h0002);
      send_beat(KIND_QUERY, 8'h55, 1'b0, 16'h0003);     // mixed, insert on dead walk
      send_beat(KIND_INSERT, 8'h66, 1'b1, 16'h0004);
      send_beat(KIND_QUERY, 8'h00, 1'b0, 16'h0005);     // mixed, insert succeeds
      send_beat(KIND_INSERT, 8'h42, 1'b1, 16'h8001);
      send_text(KIND_QUERY, '{8'h00, 8'h42}, 16'h0000);
   endtask

   task automatic test_random_strings();
      int sel;
      int goal;
      for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(0, 255));
      goal = beats_sent + 250;
      while (beats_sent < goal) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         sel = int'($urandom_range(0, 9));
         if (sel < 4)      send_string(KIND_INSERT, int'($urandom_range(1, 4)), 1'b0, 1'b0);
         else if (sel < 8) send_string(KIND_QUERY, int'($urandom_range(1, 6)), 1'b0, 1'b0);
         else if (sel < 9) send_string(kind_type'($urandom_range(0, 1)),
                                       int'($urandom_range(1, 5)), 1'b0, 1'b1);
         else              send_string(kind_type'($urandom_range(0, 1)),
                                       int'($urandom_range(1, 5)), 1'b1, 1'b1);
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_table_full();
      logic [7:0] saved[$];
      logic [7:0] stem[$];
      while (nodes_used < NODES) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         send_string(KIND_INSERT, int'($urandom_range(2, 6)), 1'b1, 1'b0);
      end
      burst_mode = 1'b0;
      saved = last_key;
      repeat (4) send_string(KIND_INSERT, 3, 1'b1, 1'b0);   // runs out mid-key
      send_text(KIND_INSERT, saved, 16'hbeef);
      stem = {stem, saved[0]};
      send_text(KIND_INSERT, stem, 16'h7531);               // existing path, no new node
      send_text(KIND_QUERY, saved, 16'h0000);
      saved = {saved, 8'($urandom_range(0, 255))};
      send_text(KIND_QUERY, saved, 16'h0000);
      repeat (20) send_string(kind_type'($urandom_range(0, 1)),
                              int'($urandom_range(1, 4)),
                              1'($urandom_range(0, 1)), 1'b0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got = rsp_data;
         if (due_rsps.size() == 0) begin
            $error("response with none expected: %p", got);
            errors++;
         end else begin
            want = due_rsps.pop_front();
            rsps_checked++;
            status_seen[want.status]++;
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               errors++;
            end
            if (got.exact_hit !== want.exact_hit) begin
               $error("exact_hit: expected %0d, got %0d", want.exact_hit, got.exact_hit);
               errors++;
            end
            if (got.prefix_hit !== want.prefix_hit) begin
               $error("prefix_hit: expected %0d, got %0d", want.prefix_hit, got.prefix_hit);
               errors++;
            end
            if (got.match_value !== want.match_value) begin
               $error("match_value: expected %h, got %h", want.match_value, got.match_value);
               errors++;
            end
            if (got.match_length !== want.match_length) begin
               $error("match_length: expected %0d, got %0d",
                      want.match_length, got.match_length);
               errors++;
            end
         end
      end
   end

   initial begin
      errors       = 0;
      beats_sent   = 0;
      rsps_checked = 0;
      burst_mode   = 1'b0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < NODES * 256; i++) child_of[i] = '0;
      for (int i = 0; i < NODES; i++) begin
         node_valid[i] = 1'b0;
         node_val[i]   = '0;
      end
      nodes_used = 1;
      restart_walk();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_strings();
      test_table_full();

      start <= 1'b0;
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d byte beats, checked %0d responses, trie filled to %0d nodes",
               beats_sent, rsps_checked, nodes_used);
      $display("inserted %0d, duplicate %0d, full %0d, answered %0d",
               status_seen[RSP_INSERTED], status_seen[RSP_DUPLICATE],
               status_seen[RSP_FULL], status_seen[RSP_ANSWER]);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/trie_lpm_pkg.sv
hw/rtl/trie_lpm_ram.sv
hw/rtl/trie_lpm_ctrl.sv
hw/rtl/trie_lpm_dpath.sv
hw/rtl/trie_lpm_top.sv
test/testbench.sv
